/* design/lzss_byte_decompressor_macros.svh */
// ============================================================================
// LZSS byte decompressor assertion macros
// Shared property wrappers for the concurrent checks in the RTL.
// ============================================================================
`ifndef LZSS_BYTE_DECOMPRESSOR_MACROS_SVH
`define LZSS_BYTE_DECOMPRESSOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define LZSBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define LZSBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/lzsbd_pkg.sv */
// ============================================================================
// LZSS byte decompressor package
// Constants, phase codes and controller/datapath interface types.
// ============================================================================
package lzsbd_pkg;

   // history window
   localparam int HIST_DEPTH = 4096;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);

   // length counter default width and output width
   localparam int LEN_BITS_DEF = 24;
   localparam int OUT_LEN_W    = 24;

   // copy run counter: up to 16 bytes remaining after the current one
   localparam int CNT_W = 5;

   // stream parser phases
   localparam logic [1:0] PH_TAG  = 2'd0;
   localparam logic [1:0] PH_LIT  = 2'd1;
   localparam logic [1:0] PH_DIST = 2'd2;

   // controller commands
   typedef struct packed {
      logic accept;    // input word taken this cycle
      logic rd_issue;  // read history at the copy source
      logic cp_emit;   // write and emit the fetched copy byte
   } cmd_type;

   // datapath status
   typedef struct packed {
      logic copy_start;  // presented word starts a back-reference copy
      logic copy_last;   // current copy byte is the last of its run
      logic out_free;    // output register can take a word this cycle
   } sts_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_WRITE = 3'b100
   } state_type;

endpackage

/* design/lzsbd_ctrl.sv */
// ============================================================================
// LZSS byte decompressor controller
// Sequences input acceptance and the read/write steps of a history copy.
// ============================================================================
`include "lzss_byte_decompressor_macros.svh"

module lzsbd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lzsbd_pkg::sts_type sts,
   output lzsbd_pkg::cmd_type cmd
);
   import lzsbd_pkg::*;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = !sts.out_free;
            cmd.accept = req_valid && sts.out_free;
            if (cmd.accept && sts.copy_start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_WRITE;
         end
         ST_WRITE: begin
            if (sts.out_free) begin
               cmd.cp_emit = 1'b1;
               state_in    = sts.copy_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   `LZSBD_ASSERT_NEXT(a_read_then_write, clock, reset, state_ff == ST_READ, state_ff == ST_WRITE, "read step not followed by write step")
   `LZSBD_ASSERT_NOW(a_emit_needs_room, clock, reset, cmd.cp_emit, sts.out_free, "copy byte emitted into a full output register")
   `LZSBD_ASSERT_NEXT(a_write_holds, clock, reset, (state_ff == ST_WRITE) && !sts.out_free, state_ff == ST_WRITE, "write step left while output blocked")

endmodule

/* design/lzsbd_datapath.sv */
// ============================================================================
// LZSS byte decompressor datapath
// Stream parser state, 4 KB history memory, length counter, output register.
// ============================================================================
`include "lzss_byte_decompressor_macros.svh"

module lzsbd_datapath #(
   parameter int LENGTH_BITS = lzsbd_pkg::LEN_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [7:0]                     req_in_byte,
   input  logic                           req_start_of_stream,
   input  lzsbd_pkg::cmd_type             cmd,
   output lzsbd_pkg::sts_type             sts,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_last_of_run,
   output logic                           rsp_end_of_stream,
   output logic [lzsbd_pkg::OUT_LEN_W-1:0] rsp_total_length
);
   import lzsbd_pkg::*;

   // history memory
   logic [7:0]         hist_mem [HIST_DEPTH];
   logic               mem_we;
   logic [HIST_AW-1:0] mem_waddr;
   logic [7:0]         mem_wdata;
   logic [HIST_AW-1:0] rd_addr;
   logic [7:0]         rd_data_ff;
   logic               rd_ok_ff, rd_ok_in;

   // parser and window state
   logic [HIST_AW-1:0]     wp_ff, wp_in;
   logic                   wrapped_ff, wrapped_in;
   logic [7:0]             flags_ff, flags_in;
   logic [2:0]             fidx_ff, fidx_in;
   logic [1:0]             phase_ff, phase_in;
   logic [7:0]             pend_ff, pend_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   ended_ff, ended_in;
   logic [HIST_AW-1:0]     dist_ff, dist_in;
   logic [CNT_W-1:0]       remain_ff, remain_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_end_ff, out_end_in;
   logic [OUT_LEN_W-1:0] out_len_ff, out_len_in;
   logic                 out_load;

   logic [1:0]                       phase_eff;
   logic                             ended_eff;
   logic [LENGTH_BITS+OUT_LEN_W-1:0] len_ext;

   // start of stream overrides the stored phase and end flag
   assign phase_eff = req_start_of_stream ? PH_TAG : phase_ff;
   assign ended_eff = req_start_of_stream ? 1'b0 : ended_ff;

   // copy source and whether it has been written since the stream began
   assign rd_addr  = wp_ff - dist_ff;
   assign rd_ok_in = wrapped_ff || (rd_addr < wp_ff);

   // status to the controller
   assign sts.copy_start = (phase_eff == PH_DIST) && !ended_eff;
   assign sts.copy_last  = (remain_ff == '0);
   assign sts.out_free   = !out_valid_ff || !rsp_stall;

   // reported length, fitted to the output width
   assign len_ext    = {{OUT_LEN_W{1'b0}}, len_in};
   assign out_len_in = len_ext[OUT_LEN_W-1:0];

   // parser, window update and output load
   always_comb begin
      wp_in       = wp_ff;
      wrapped_in  = wrapped_ff;
      flags_in    = flags_ff;
      fidx_in     = fidx_ff;
      phase_in    = phase_ff;
      pend_in     = pend_ff;
      len_in      = len_ff;
      ended_in    = ended_ff;
      dist_in     = dist_ff;
      remain_in   = remain_ff;
      mem_we      = 1'b0;
      mem_waddr   = wp_ff;
      mem_wdata   = req_in_byte;
      out_load    = 1'b0;
      out_byte_in = req_in_byte;
      out_last_in = 1'b1;
      out_end_in  = 1'b0;

      if (cmd.accept) begin
         if (req_start_of_stream) begin
            wp_in      = '0;
            wrapped_in = 1'b0;
            flags_in   = '0;
            fidx_in    = '0;
            phase_in   = PH_TAG;
            pend_in    = '0;
            len_in     = '0;
            ended_in   = 1'b0;
         end
         if (!ended_eff) begin
            case (phase_eff)
               PH_LIT: begin
                  if (!flags_ff[7]) begin
                     // literal
                     mem_we      = 1'b1;
                     mem_wdata   = req_in_byte;
                     out_load    = 1'b1;
                     out_byte_in = req_in_byte;
                     flags_in    = {flags_ff[6:0], 1'b0};
                     fidx_in     = fidx_ff + 3'd1;
                     phase_in    = (fidx_in == 3'd0) ? PH_TAG : PH_LIT;
                  end else if (req_in_byte == 8'h00) begin
                     // end marker
                     ended_in    = 1'b1;
                     out_load    = 1'b1;
                     out_byte_in = 8'h00;
                     out_end_in  = 1'b1;
                  end else begin
                     pend_in  = req_in_byte;
                     phase_in = PH_DIST;
                  end
               end
               PH_DIST: begin
                  // low distance byte: set up the copy run
                  dist_in   = {pend_ff[7:4], req_in_byte};
                  remain_in = {1'b0, pend_ff[3:0]} + CNT_W'(1);
                  pend_in   = '0;
                  flags_in  = {flags_ff[6:0], 1'b0};
                  fidx_in   = fidx_ff + 3'd1;
                  phase_in  = (fidx_in == 3'd0) ? PH_TAG : PH_LIT;
               end
               default: begin
                  flags_in = req_in_byte;
                  fidx_in  = '0;
                  phase_in = PH_LIT;
               end
            endcase
         end
      end

      // one copy byte from the fetched history entry
      if (cmd.cp_emit) begin
         mem_we      = 1'b1;
         mem_wdata   = rd_ok_ff ? rd_data_ff : 8'h00;
         out_load    = 1'b1;
         out_byte_in = mem_wdata;
         out_last_in = (remain_ff == '0);
         remain_in   = remain_ff - CNT_W'(1);
      end

      // every byte written to history advances the window and the length
      mem_waddr = wp_in;
      if (mem_we) begin
         wp_in = wp_in + HIST_AW'(1);
         if (wp_in == '0) begin
            wrapped_in = 1'b1;
         end
         if (len_in != '1) begin
            len_in = len_in + LENGTH_BITS'(1);
         end
      end

      out_valid_in = out_load || (out_valid_ff && rsp_stall);
   end

   // history memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= hist_mem[rd_addr];
         rd_ok_ff   <= rd_ok_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         flags_ff     <= '0;
         fidx_ff      <= '0;
         phase_ff     <= PH_TAG;
         pend_ff      <= '0;
         len_ff       <= '0;
         ended_ff     <= 1'b0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         flags_ff     <= flags_in;
         fidx_ff      <= fidx_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         len_ff       <= len_in;
         ended_ff     <= ended_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      if (out_load) begin
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
         out_end_ff  <= out_end_in;
         out_len_ff  <= out_len_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_last_of_run   = out_last_ff;
   assign rsp_end_of_stream = out_end_ff;
   assign rsp_total_length  = out_len_ff;

   // checks
   `LZSBD_ASSERT_NEXT(a_run_end_last, clock, reset,
      cmd.cp_emit && (remain_ff == '0), rsp_last_of_run,
      "final copy byte not marked last")
   `LZSBD_ASSERT_NOW(a_end_is_last, clock, reset,
      rsp_valid && rsp_end_of_stream, rsp_last_of_run && (rsp_out_byte == 8'h00),
      "end word malformed")
   `LZSBD_ASSERT_NOW(a_no_load_when_full, clock, reset,
      out_valid_ff && rsp_stall, !out_load,
      "output register overwritten while stalled")

endmodule

/* design/lzss_byte_decompressor.sv */
// LZSS decompressor with a 4 KB history window. Compressed bytes enter one word
// at a time on the req_ channel; decompressed bytes leave on the rsp_ channel.
// Tag, count and literal words need no extra steps. A low distance word that
// starts a back-reference of N bytes (2 to 17) stalls the input until the copy
// is done, as every copied byte needs a read of the single history memory
// followed by its write-back, so an overlapping copy sees the byte it just
// produced. Input is taken only while the output register is empty or being
// drained, so a word held there by rsp_stall also stalls the input.
// start_of_stream takes effect at once: the window is tracked with a write
// pointer and a wrap flag, so no clearing pass runs and unwritten history
// reads as zero.
// ============================================================================
// LZSS byte decompressor top level
// Joins the controller and the datapath.
// ============================================================================
module lzss_byte_decompressor #(
   parameter int LENGTH_BITS = lzsbd_pkg::LEN_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_in_byte,
   input  logic                            req_start_of_stream,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last_of_run,
   output logic                            rsp_end_of_stream,
   output logic [lzsbd_pkg::OUT_LEN_W-1:0] rsp_total_length
);
   import lzsbd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   lzsbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // parser, history and output register
   lzsbd_datapath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_in_byte         (req_in_byte),
      .req_start_of_stream (req_start_of_stream),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_last_of_run     (rsp_last_of_run),
      .rsp_end_of_stream   (rsp_end_of_stream),
      .rsp_total_length    (rsp_total_length)
   );

endmodule
